// ===== hw/rtl/efr_pkg.sv =====
package efr_pkg;

  // Depth of the frame buffer and the widths that follow from it.
  localparam int unsigned BufDepth = 64;
  localparam int unsigned IdxW     = $clog2(BufDepth);
  localparam int unsigned WidxW    = IdxW + 1;

  // Framing bytes.
  localparam logic [7:0] StartByte   = 8'h7E;
  localparam logic [7:0] EndByte     = 8'h7B;
  localparam logic [7:0] EscPrefixA  = 8'h7D;
  localparam logic [7:0] EscPrefixB  = 8'h7A;
  localparam logic [7:0] EscStart    = 8'h5E;
  localparam logic [7:0] EscPrefA    = 8'h5D;
  localparam logic [7:0] EscEnd      = 8'h5B;
  localparam logic [7:0] EscPrefB    = 8'h5A;
  localparam logic [7:0] SizeUnknown = 8'hFF;

  // Register reset values.
  localparam logic [5:0] LengthPosRst = 6'd3;
  localparam logic [5:0] OverheadRst  = 6'd5;
  localparam logic [6:0] MaxSizeRst   = 7'd40;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgLengthPos = 2'd0,
    CfgOverhead  = 2'd1,
    CfgMaxSize   = 2'd2
  } cfg_idx_e;

  // Request codes on the input channel.
  typedef enum logic {
    ReqByte  = 1'b0,
    ReqClear = 1'b1
  } req_e;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } decode_t;

  // One result transaction.
  typedef struct packed {
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic       frame_ready;
    logic       length_clamped;
    logic       too_short;
    logic       end_at_limit;
    logic       overflow_drop;
  } result_t;

  // Decodes a prefix byte followed by its escape partner.
  function automatic decode_t decode_pair(logic [7:0] prefix, logic [7:0] partner);
    decode_t d;
    d.hit   = 1'b1;
    d.value = partner;
    if (prefix == EscPrefixA && partner == EscStart) begin
      d.value = StartByte;
    end else if (prefix == EscPrefixA && partner == EscPrefA) begin
      d.value = EscPrefixA;
    end else if (prefix == EscPrefixB && partner == EscEnd) begin
      d.value = EndByte;
    end else if (prefix == EscPrefixB && partner == EscPrefB) begin
      d.value = EscPrefixB;
    end else begin
      d.hit = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/efr_out_buf.sv =====
module efr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  efr_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output efr_pkg::result_t out_data_o
);
  import efr_pkg::*;

  logic    main_v_q, main_v_d;
  logic    skid_v_q, skid_v_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = main_v_q && !out_stall_i;

  // The skid entry catches a result that arrives while the output is stalled.
  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push_i;
        main_d   = push_data_i;
      end
    end else if (!main_v_q) begin
      main_v_d = push_i;
      main_d   = push_data_i;
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

endmodule

// ===== hw/rtl/escaped_frame_receiver.sv =====
// Byte-stuffed, length-framed receiver for a serial byte stream.
// Input channel (in_valid_i / in_stall_o): each transaction carries req_type_i and
// rx_byte_i. A byte request decodes one serial byte and writes it to the frame buffer;
// a clear request drops the frame ready flag once the consumer has taken the frame.
// Every input transaction gives exactly one result transaction on the output channel
// (out_valid_o / out_stall_i) with the store position, the decoded byte and the flags.
// The result of an accepted item is registered in the output buffer. Throughput is one
// item per cycle while the output buffer is not full; the decode, the size compare and the
// single frame buffer write port all fit in the cycle in which the item is accepted.
// A two-entry output buffer separates the channels, so an item is still accepted while
// one result waits; in_stall_o rises only when both entries hold results.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and must only be written
// while the block is idle. Index 0 is the length position, 1 the frame overhead,
// 2 the maximum frame size; other indexes are ignored.
// Reset empties the output buffer, restores the register defaults and sets the frame
// state to an empty frame of unknown size. The frame buffer itself is not cleared.
module escaped_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       store_valid_o,
  output logic [5:0] store_index_o,
  output logic [7:0] store_byte_o,
  output logic       frame_ready_o,
  output logic       length_clamped_o,
  output logic       too_short_o,
  output logic       end_at_limit_o,
  output logic       overflow_drop_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  import efr_pkg::*;

  // Configuration registers.
  logic [5:0] length_pos_q;
  logic [5:0] overhead_q;
  logic [6:0] max_size_q;

  // Frame state.
  logic [WidxW-1:0] widx_q, widx_d;
  logic [7:0]       frame_size_q, frame_size_d;
  logic [7:0]       last_byte_q, last_byte_d;
  logic             last_raw_q, last_raw_d;
  logic             ready_q, ready_d;

  // Frame buffer, one write port driven by the store of each byte.
  logic [7:0] frame_buf_q [BufDepth];

  logic             accept;
  logic             buf_full;
  result_t          res;
  decode_t          dec;
  logic [WidxW-1:0] widx_esc;
  logic [WidxW-1:0] widx_pos;
  logic [WidxW-1:0] widx_inc;
  logic [7:0]       value;
  logic [8:0]       size_sum;
  logic             store_en;
  logic [IdxW-1:0]  store_addr;
  result_t          out_data;

  assign accept      = in_valid_i && !buf_full;
  assign in_stall_o  = buf_full;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_pos_q <= LengthPosRst;
      overhead_q   <= OverheadRst;
      max_size_q   <= MaxSizeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLengthPos: length_pos_q <= cfg_data_i[5:0];
        CfgOverhead:  overhead_q   <= cfg_data_i[5:0];
        CfgMaxSize:   max_size_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // One byte is handled completely in the cycle it is accepted. The steps run in the
  // order of the framing rules: escape undo, length capture, early end, store.
  always_comb begin
    widx_d       = widx_q;
    frame_size_d = frame_size_q;
    last_byte_d  = last_byte_q;
    last_raw_d   = last_raw_q;
    ready_d      = ready_q;
    res          = '0;
    dec          = decode_pair(last_byte_q, rx_byte_i);
    value        = rx_byte_i;
    widx_esc     = widx_q;
    widx_pos     = widx_q;
    widx_inc     = widx_q;
    size_sum     = '0;
    store_en     = 1'b0;
    store_addr   = '0;

    if (req_type_i == ReqClear) begin
      ready_d = 1'b0;
    end else if (rx_byte_i == StartByte) begin
      widx_d       = '0;
      frame_size_d = SizeUnknown;
      last_raw_d   = 1'b0;
    end else begin
      // A raw prefix followed by its partner folds back onto the prefix slot.
      if (last_raw_q && widx_q != '0 && dec.hit) begin
        value    = dec.value;
        widx_esc = widx_q - WidxW'(1);
      end

      if (widx_esc == {1'b0, length_pos_q}) begin
        size_sum = {1'b0, value} + {3'b000, overhead_q};
        if (size_sum > {2'b00, max_size_q}) begin
          frame_size_d       = {1'b0, max_size_q};
          res.length_clamped = 1'b1;
        end else begin
          frame_size_d = size_sum[7:0];
        end
      end

      widx_pos = widx_esc;
      // An end byte before the declared size restarts the frame at the end byte.
      if (rx_byte_i == EndByte && {{(8 - WidxW){1'b0}}, widx_esc} < frame_size_d) begin
        res.too_short = 1'b1;
        ready_d       = 1'b0;
        widx_pos      = '0;
      end

      if (widx_pos < WidxW'(BufDepth)) begin
        store_en        = 1'b1;
        store_addr      = widx_pos[IdxW-1:0];
        widx_inc        = widx_pos + WidxW'(1);
        widx_d          = widx_inc;
        last_byte_d     = value;
        last_raw_d      = !(widx_esc != widx_q);
        res.store_valid = 1'b1;
        res.store_index = widx_pos[5:0];
        res.store_byte  = value;
        if ({{(8 - WidxW){1'b0}}, widx_inc} == frame_size_d) begin
          if (rx_byte_i == EndByte) begin
            res.end_at_limit = 1'b1;
          end else begin
            ready_d = 1'b1;
          end
        end
      end else begin
        widx_d            = widx_pos;
        res.overflow_drop = 1'b1;
        last_raw_d        = 1'b0;
      end
    end
    res.frame_ready = ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q       <= '0;
      frame_size_q <= SizeUnknown;
      last_byte_q  <= '0;
      last_raw_q   <= 1'b0;
      ready_q      <= 1'b0;
    end else if (accept) begin
      widx_q       <= widx_d;
      frame_size_q <= frame_size_d;
      last_byte_q  <= last_byte_d;
      last_raw_q   <= last_raw_d;
      ready_q      <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && store_en) begin
      frame_buf_q[store_addr] <= value;
    end
  end

  efr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign store_valid_o    = out_data.store_valid;
  assign store_index_o    = out_data.store_index;
  assign store_byte_o     = out_data.store_byte;
  assign frame_ready_o    = out_data.frame_ready;
  assign length_clamped_o = out_data.length_clamped;
  assign too_short_o      = out_data.too_short;
  assign end_at_limit_o   = out_data.end_at_limit;
  assign overflow_drop_o  = out_data.overflow_drop;

  // The write index never runs past the buffer depth.
  a_widx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= WidxW'(BufDepth))
    else $error("write index beyond buffer depth");

  // An early end byte is always stored at the head of the buffer.
  a_short_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_short_o |-> store_valid_o && store_index_o == '0)
    else $error("too-short result not stored at index zero");

  // A dropped byte is never reported as stored.
  a_drop_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_drop_o |-> !store_valid_o)
    else $error("dropped byte reported as stored");

  // The input side only stalls while a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // An accepted clear request always leaves the ready flag low.
  a_ready_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == ReqClear |=> !ready_q)
    else $error("ready flag survived a clear request");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import efr_pkg::*;

  // A byte transaction as the sender offers it: a received byte or a clear request.
  typedef struct packed {
    req_e       req;
    logic [7:0] data;
  } rx_item_t;

  // The watchdog ends the run after this many cycles in which nothing is accepted.
  localparam int unsigned StallLimit = 1000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       req_type_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       store_valid_o;
  logic [5:0] store_index_o;
  logic [7:0] store_byte_o;
  logic       frame_ready_o;
  logic       length_clamped_o;
  logic       too_short_o;
  logic       end_at_limit_o;
  logic       overflow_drop_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = 2'd0;
  logic [6:0] cfg_data_i = 7'd0;

  escaped_frame_receiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .store_valid_o   (store_valid_o),
    .store_index_o   (store_index_o),
    .store_byte_o    (store_byte_o),
    .frame_ready_o   (frame_ready_o),
    .length_clamped_o(length_clamped_o),
    .too_short_o     (too_short_o),
    .end_at_limit_o  (end_at_limit_o),
    .overflow_drop_o (overflow_drop_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Our own copy of the deframer state and of its registers. The frame buffer is only
  // ever written by the block, so its contents are not tracked here.
  int         fr_widx = 0;
  int         fr_size = 255;
  logic [7:0] fr_last_byte = 8'h00;
  logic       fr_last_raw = 1'b0;
  logic       fr_ready = 1'b0;
  logic [5:0] fr_len_pos = LengthPosRst;
  logic [5:0] fr_overhead = OverheadRst;
  logic [6:0] fr_max_size = MaxSizeRst;

  rx_item_t rx_items_q[$];    // Byte transactions still to be offered to the block.
  result_t  deframed_q[$];    // Results worked out for accepted bytes, oldest first.
  int       items_queued = 0;
  int       items_taken = 0;
  int       results_seen = 0;
  int       mismatches = 0;

  // Works out the result of one byte transaction and advances our copy of the state.
  // The decision order matters: an escape pair first steps the index back onto its
  // prefix, then the length field is looked at, then the early end, then the store.
  function automatic result_t deframe_byte(req_e req, logic [7:0] raw);
    result_t    res;
    logic [7:0] val;
    logic       esc;
    int         sz;
    res = '0;
    val = raw;
    esc = 1'b0;
    if (req == ReqClear) begin
      fr_ready = 1'b0;
    end else if (raw == StartByte) begin
      fr_widx = 0;
      fr_size = int'(SizeUnknown);
      fr_last_raw = 1'b0;
    end else begin
      // Only a prefix that was itself stored raw can start an escape.
      if (fr_last_raw && fr_widx > 0) begin
        esc = 1'b1;
        case ({fr_last_byte, raw})
          {EscPrefixA, EscStart}: val = StartByte;
          {EscPrefixA, EscPrefA}: val = EscPrefixA;
          {EscPrefixB, EscEnd}:   val = EndByte;
          {EscPrefixB, EscPrefB}: val = EscPrefixB;
          default:                esc = 1'b0;
        endcase
        if (esc) begin
          fr_widx--;
        end
      end
      if (fr_widx == int'(fr_len_pos)) begin
        sz = int'(val) + int'(fr_overhead);
        if (sz > int'(fr_max_size)) begin
          sz = int'(fr_max_size);
          res.length_clamped = 1'b1;
        end
        fr_size = sz;
      end
      // Only a raw end byte ends a frame; one that comes early restarts it at zero.
      if (raw == EndByte && fr_widx < fr_size) begin
        res.too_short = 1'b1;
        fr_ready = 1'b0;
        fr_widx = 0;
      end
      if (fr_widx < int'(BufDepth)) begin
        res.store_valid = 1'b1;
        res.store_index = fr_widx[5:0];
        res.store_byte = val;
        fr_widx++;
        fr_last_byte = val;
        fr_last_raw = !esc;
        if (fr_widx == fr_size) begin
          if (raw == EndByte) begin
            res.end_at_limit = 1'b1;
          end else begin
            fr_ready = 1'b1;
          end
        end
      end else begin
        // The buffer is full: the byte is lost and cannot serve as an escape prefix.
        res.overflow_drop = 1'b1;
        fr_last_raw = 1'b0;
      end
    end
    res.frame_ready = fr_ready;
    return res;
  endfunction

  function automatic void push_raw(logic [7:0] b);
    rx_items_q.push_back('{ReqByte, b});
    items_queued++;
  endfunction

  function automatic void push_clear(logic [7:0] b);
    rx_items_q.push_back('{ReqClear, b});
    items_queued++;
  endfunction

  // Sends one decoded value the way a well-behaved transmitter would, with the four
  // framing values replaced by their escape pairs.
  function automatic void push_decoded(logic [7:0] v);
    case (v)
      StartByte: begin
        push_raw(EscPrefixA);
        push_raw(EscStart);
      end
      EscPrefixA: begin
        push_raw(EscPrefixA);
        push_raw(EscPrefA);
      end
      EndByte: begin
        push_raw(EscPrefixB);
        push_raw(EscEnd);
      end
      EscPrefixB: begin
        push_raw(EscPrefixB);
        push_raw(EscPrefB);
      end
      default: push_raw(v);
    endcase
  endfunction

  // Frame content leans on the four framing values so that escapes are frequent.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 11))
      0:       return StartByte;
      1:       return EndByte;
      2:       return EscPrefixA;
      3:       return EscPrefixB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Writes one register through the configuration port and mirrors it on acceptance.
  task automatic write_reg(cfg_idx_e idx, logic [6:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgLengthPos: fr_len_pos = value[5:0];
      CfgOverhead:  fr_overhead = value[5:0];
      CfgMaxSize:   fr_max_size = value;
      default:      ;
    endcase
  endtask

  task automatic set_regs(int len_pos, int overhead, int max_size);
    write_reg(CfgLengthPos, 7'(len_pos));
    write_reg(CfgOverhead, 7'(overhead));
    write_reg(CfgMaxSize, 7'(max_size));
  endtask

  // Holds the sender back until every byte has been taken and every result checked.
  task automatic drain();
    do @(posedge clk_i); while (items_taken != items_queued || deframed_q.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // One random phase: most of the traffic is well-formed frames whose length field
  // names the real size, so frames complete. The rest is truncated frames closed by an
  // early end byte, frames that run on past their size and sometimes past the buffer,
  // and plain noise with bare prefixes and stray partners.
  task automatic run_random_phase(int len_pos, int overhead, int max_size, int count);
    int first;
    int kind;
    int goal;
    int len_val;
    int body;
    first = items_queued;
    set_regs(len_pos, overhead, max_size);
    while (items_queued - first < count) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 80)) push_raw(8'($urandom_range(0, 255)));
      end else begin
        push_raw(StartByte);
        goal = int'(fr_len_pos) + 1 + $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0) begin
          goal = $urandom_range(1, 70);
        end
        len_val = goal - int'(fr_overhead);
        if (len_val < 0 || len_val > 255) begin
          len_val = $urandom_range(0, 255);
        end
        body = goal;
        if (kind >= 6 && kind <= 7) begin
          body = $urandom_range(0, goal - 1);
        end else if (kind == 8) begin
          body = goal + $urandom_range(1, 70);
        end
        for (int i = 0; i < body; i++) begin
          push_decoded((i == int'(fr_len_pos)) ? 8'(len_val) : payload_byte());
        end
        if ((kind >= 6 && kind <= 7) || $urandom_range(0, 3) == 0) begin
          push_raw(EndByte);
        end
      end
      // The consumer takes the frame now and then; the byte lane carries junk.
      if ($urandom_range(0, 1) == 0) begin
        push_clear(8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  // Sender: offers queued transactions in bursts of random length with random gaps in
  // between. A transaction once offered stays put until the block takes it.
  rx_item_t next_item;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= ReqByte;
      rx_byte_i <= 8'h00;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframed_q.push_back(deframe_byte(req_e'(req_type_i), rx_byte_i));
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 || rx_items_q.size() == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end
          in_valid_i <= 1'b0;
        end else begin
          next_item = rx_items_q.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= next_item.req;
          rx_byte_i <= next_item.data;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: checks each result transaction against the oldest outstanding one and
  // stalls on a pattern of its own. The stall density changes every so often, from
  // none at all to nearly always. Now and then it holds off for a long stretch; the
  // first such stretch is forced once the run is well under way and plenty of bytes
  // are still waiting, so that the output buffer fills and the input stalls.
  result_t got_res;
  result_t want_res;
  int      hold_left = 0;
  int      pattern_left = 0;
  int      stall_pct = 0;
  logic    long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      pattern_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_res = {store_valid_o, store_index_o, store_byte_o, frame_ready_o,
                   length_clamped_o, too_short_o, end_at_limit_o, overflow_drop_o};
        results_seen++;
        if (deframed_q.size() == 0) begin
          $error("result transaction arrived with none outstanding");
          mismatches++;
        end else begin
          want_res = deframed_q.pop_front();
          check_field("store_valid", want_res.store_valid, got_res.store_valid);
          check_field("store_index", want_res.store_index, got_res.store_index);
          check_field("store_byte", want_res.store_byte, got_res.store_byte);
          check_field("frame_ready", want_res.frame_ready, got_res.frame_ready);
          check_field("length_clamped", want_res.length_clamped, got_res.length_clamped);
          check_field("too_short", want_res.too_short, got_res.too_short);
          check_field("end_at_limit", want_res.end_at_limit, got_res.end_at_limit);
          check_field("overflow_drop", want_res.overflow_drop, got_res.overflow_drop);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && results_seen >= 300 && rx_items_q.size() > 16) begin
        long_hold_done = 1'b1;
        hold_left = $urandom_range(80, 150);
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 599) == 0) begin
        hold_left = $urandom_range(30, 120);
        out_stall_i <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 200);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 30;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end else begin
          pattern_left--;
        end
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: a run that stops accepting anything for too long has hung.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Stimulus sequence: two directed phases, then random phases over a spread of
  // register settings, with the register extremes among them.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: length at index 3, overhead 5, limit 40. A clear with nothing
    // ready, then a frame of size 7 in which every byte from index 2 on but the length is
    // an escape pair; it completes and is cleared by the consumer.
    push_clear(8'hFF);
    push_raw(StartByte);
    push_raw(8'h00);
    push_raw(8'hFF);
    push_decoded(StartByte);
    push_raw(8'h02);
    push_decoded(EndByte);
    push_decoded(EscPrefixA);
    push_decoded(EscPrefixB);
    push_clear(8'h00);
    // A raw end byte in the length position: the size is clamped and the frame is
    // too short, so the end byte lands at index zero. An escape pair follows.
    push_raw(StartByte);
    push_raw(8'h11);
    push_raw(8'h22);
    push_raw(8'h33);
    push_raw(EndByte);
    push_decoded(StartByte);
    // An escape partner with no prefix before it is plain data.
    push_raw(StartByte);
    push_raw(EscPrefA);
    drain();

    // Length at index 0, no overhead, limit 1. An end byte right after the start is
    // too short and then sits exactly on the last position; a zero length gives a
    // size that is never reached; a length of 5 is clamped to 1 and completes.
    set_regs(0, 0, 1);
    push_raw(StartByte);
    push_raw(EndByte);
    push_raw(StartByte);
    push_raw(8'h00);
    push_raw(StartByte);
    push_raw(8'h05);
    push_clear(8'h5A);
    drain();

    run_random_phase(3, 5, 40, 205);
    run_random_phase(63, 63, 64, 205);
    run_random_phase(0, 63, 64, 205);
    run_random_phase(10, 0, 1, 205);
    run_random_phase(5, 0, 127, 205);
    run_random_phase($urandom_range(0, 20), $urandom_range(0, 63), $urandom_range(1, 64), 205);
    run_random_phase(1, 2, 8, 205);
    run_random_phase($urandom_range(0, 20), $urandom_range(0, 63), $urandom_range(1, 64), 205);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/efr_pkg.sv
hw/rtl/efr_out_buf.sv
hw/rtl/escaped_frame_receiver.sv
test/tb_top.sv
